/* design/ubx_fp_pkg.sv */
// Shared types, codes and helpers for the UBX frame parser.
// No dependencies; imported by the parser, the result queue, the top level and the testbench.
`timescale 1ns / 1ps

package ubx_fp_pkg;

    // frame framing bytes
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // message classes and ids of interest
    localparam logic [7:0] CLASS_NAV        = 8'h01;
    localparam logic [7:0] CLASS_RXM        = 8'h02;
    localparam logic [7:0] ID_NAV_PVT       = 8'h07;
    localparam logic [7:0] ID_NAV_HPPOSLLH  = 8'h14;
    localparam logic [7:0] ID_NAV_RELPOSNED = 8'h3C;
    localparam logic [7:0] ID_NAV_SIG       = 8'h43;
    localparam logic [7:0] ID_RXM_RTCM      = 8'h32;

    // minimum payload lengths for a valid update
    localparam logic [15:0] PVT_MIN_LEN    = 16'd44;
    localparam logic [15:0] HPPOS_MIN_LEN  = 16'd32;
    localparam logic [15:0] RELPOS_MIN_LEN = 16'd64;
    localparam logic [15:0] SIG_MIN_LEN    = 16'd8;

    // frame status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_CK_A = 2'd1;
    localparam logic [1:0] STAT_BAD_CK_B = 2'd2;

    // message kind codes
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_PVT    = 3'd1;
    localparam logic [2:0] KIND_HPPOS  = 3'd2;
    localparam logic [2:0] KIND_RELPOS = 3'd3;
    localparam logic [2:0] KIND_SIG    = 3'd4;
    localparam logic [2:0] KIND_RTCM   = 3'd5;

    // carrier solution code that is reported as invalid
    localparam logic [1:0] CARR_RESERVED = 2'd3;
    localparam logic [1:0] CARR_INVALID  = 2'd0;

    typedef struct packed {
        logic [1:0]         frame_status;
        logic [7:0]         message_class;
        logic [7:0]         message_id;
        logic [15:0]        payload_length;
        logic [2:0]         message_kind;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic [31:0]        accuracy_raw;
        logic signed [7:0]  lat_fine;
        logic signed [7:0]  lon_fine;
        logic [7:0]         count_a;
        logic [7:0]         count_b;
    } t_result;

    // Drop byte b into its little-endian lane of w when payload offset k
    // falls in the 32-bit word at word offset base_word.
    function automatic logic [31:0] put_le(input logic [31:0] w,
                                           input logic [15:0] k,
                                           input logic [13:0] base_word,
                                           input logic [7:0]  b);
        logic [31:0] r;
        r = w;
        if (k[15:2] == base_word) begin
            r[8*k[1:0] +: 8] = b;
        end
        return r;
    endfunction

endpackage

/* design/ubx_fp_byte_if.sv */
// Byte input channel of the UBX frame parser: valid/ready plus one byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface ubx_fp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* design/ubx_fp_frame_if.sv */
// Frame result channel of the UBX frame parser: valid/ready plus decoded fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface ubx_fp_frame_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic [7:0]         message_class;
    logic [7:0]         message_id;
    logic [15:0]        payload_length;
    logic [2:0]         message_kind;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic [31:0]        accuracy_raw;
    logic signed [7:0]  lat_fine;
    logic signed [7:0]  lon_fine;
    logic [7:0]         count_a;
    logic [7:0]         count_b;

    modport source (output valid, input ready, output frame_status, output message_class,
                    output message_id, output payload_length, output message_kind,
                    output value_a, output value_b, output accuracy_raw, output lat_fine,
                    output lon_fine, output count_a, output count_b);
    modport sink (input valid, output ready, input frame_status, input message_class,
                  input message_id, input payload_length, input message_kind,
                  input value_a, input value_b, input accuracy_raw, input lat_fine,
                  input lon_fine, input count_a, input count_b);
endinterface

/* design/ubx_fp_parser.sv */
// Frame state machine: sync hunt, header, payload field capture, checksum.
// Depends on ubx_fp_pkg.
`timescale 1ns / 1ps

module ubx_fp_parser import ubx_fp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic [7:0] i_byte,
    output logic    o_emit,
    output t_result o_result
);

    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN1    = 4'd4;
    localparam logic [3:0] PH_LEN2    = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CHKA    = 4'd7;
    localparam logic [3:0] PH_CHKB    = 4'd8;

    // payload word offsets (byte offset / 4), then payload byte offsets and lanes
    localparam logic [13:0] PVT_LON_WORD    = 14'd6;
    localparam logic [13:0] PVT_LAT_WORD    = 14'd7;
    localparam logic [13:0] PVT_HACC_WORD   = 14'd10;
    localparam logic [13:0] HP_LON_WORD     = 14'd2;
    localparam logic [13:0] HP_LAT_WORD     = 14'd3;
    localparam logic [13:0] HP_HACC_WORD    = 14'd7;
    localparam logic [13:0] REL_NORTH_WORD  = 14'd2;
    localparam logic [13:0] REL_EAST_WORD   = 14'd3;
    localparam logic [15:0] HP_LON_FINE_OFS = 16'd24;
    localparam logic [15:0] HP_LAT_FINE_OFS = 16'd25;
    localparam logic [15:0] REL_FLAGS_OFS   = 16'd60;
    localparam logic [15:0] SIG_COUNT_OFS   = 16'd5;
    localparam logic [15:0] SIG_FLAGS_FIRST = 16'd18;
    localparam logic [3:0]  SIG_FLAGS_LANE  = 4'd2;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_idx, n_idx;
    logic [31:0] r_cap_a, n_cap_a;
    logic [31:0] r_cap_b, n_cap_b;
    logic [31:0] r_cap_c, n_cap_c;
    logic [15:0] r_fine, n_fine;
    logic [7:0]  r_sig_limit, n_sig_limit;
    logic [7:0]  r_healthy, n_healthy;
    logic [7:0]  r_corrected, n_corrected;

    logic [7:0]  add_a, add_b;
    logic [15:0] idx_inc;
    logic [15:0] full_len;
    logic [11:0] sig_blk;
    logic        sig_flag_slot, sig_in_count, sig_in_frame, sig_good;
    logic [1:0]  status;
    logic [1:0]  carr_soln;

    assign add_a    = r_sum_a + i_byte;
    assign add_b    = r_sum_b + add_a;
    assign idx_inc  = r_idx + 16'd1;
    assign full_len = {i_byte, r_len[7:0]};

    // NAV-SIG flags byte of signal block n sits at offset 18 + 16n
    assign sig_flag_slot = (r_idx >= SIG_FLAGS_FIRST) && (r_idx[3:0] == SIG_FLAGS_LANE);
    assign sig_blk       = r_idx[15:4] - 12'd1;
    assign sig_in_count  = !r_sig_limit[7] && (sig_blk < {4'h0, r_sig_limit});
    assign sig_in_frame  = ({1'b0, r_idx} + 17'd1) < {1'b0, r_len};
    assign sig_good      = (i_byte[1:0] == 2'b01) && i_byte[3];

    always_comb begin
        n_phase     = r_phase;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_class     = r_class;
        n_id        = r_id;
        n_len       = r_len;
        n_idx       = r_idx;
        n_cap_a     = r_cap_a;
        n_cap_b     = r_cap_b;
        n_cap_c     = r_cap_c;
        n_fine      = r_fine;
        n_sig_limit = r_sig_limit;
        n_healthy   = r_healthy;
        n_corrected = r_corrected;
        o_emit      = 1'b0;
        status      = STAT_OK;

        unique case (r_phase)
            PH_SYNC2: begin
                if (i_byte == SYNC_SECOND) begin
                    n_phase = PH_CLASS;
                    n_sum_a = 8'h00;
                    n_sum_b = 8'h00;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_CLASS: begin
                n_class = i_byte;
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_byte;
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_len   = {8'h00, i_byte};
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_LEN2;
            end
            PH_LEN2: begin
                n_len       = full_len;
                n_sum_a     = add_a;
                n_sum_b     = add_b;
                n_idx       = 16'd0;
                n_cap_a     = 32'd0;
                n_cap_b     = 32'd0;
                n_cap_c     = 32'd0;
                n_fine      = 16'd0;
                n_sig_limit = 8'd0;
                n_healthy   = 8'd0;
                n_corrected = 8'd0;
                // empty payload goes straight to the checksum
                n_phase     = (full_len == 16'd0) ? PH_CHKA : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_idx   = idx_inc;
                if (idx_inc >= r_len) begin
                    n_phase = PH_CHKA;
                end
                if (r_class == CLASS_NAV) begin
                    priority if (r_id == ID_NAV_PVT) begin
                        n_cap_b = put_le(r_cap_b, r_idx, PVT_LON_WORD, i_byte);
                        n_cap_a = put_le(r_cap_a, r_idx, PVT_LAT_WORD, i_byte);
                        n_cap_c = put_le(r_cap_c, r_idx, PVT_HACC_WORD, i_byte);
                    end else if (r_id == ID_NAV_HPPOSLLH) begin
                        n_cap_b = put_le(r_cap_b, r_idx, HP_LON_WORD, i_byte);
                        n_cap_a = put_le(r_cap_a, r_idx, HP_LAT_WORD, i_byte);
                        n_cap_c = put_le(r_cap_c, r_idx, HP_HACC_WORD, i_byte);
                        if (r_idx == HP_LON_FINE_OFS) begin
                            n_fine = {r_fine[15:8], i_byte};
                        end
                        if (r_idx == HP_LAT_FINE_OFS) begin
                            n_fine = {i_byte, r_fine[7:0]};
                        end
                    end else if (r_id == ID_NAV_RELPOSNED) begin
                        n_cap_a = put_le(r_cap_a, r_idx, REL_NORTH_WORD, i_byte);
                        n_cap_b = put_le(r_cap_b, r_idx, REL_EAST_WORD, i_byte);
                        if (r_idx == REL_FLAGS_OFS) begin
                            n_fine = {8'h00, i_byte};
                        end
                    end else if (r_id == ID_NAV_SIG) begin
                        if (r_idx == SIG_COUNT_OFS) begin
                            n_sig_limit = i_byte;
                        end
                        if (sig_flag_slot && sig_in_count && sig_in_frame && sig_good) begin
                            n_healthy = r_healthy + 8'd1;
                            if (i_byte[7]) begin
                                n_corrected = r_corrected + 8'd1;
                            end
                        end
                    end else begin
                    end
                end
            end
            PH_CHKA: begin
                if (i_byte == r_sum_a) begin
                    n_phase = PH_CHKB;
                end else begin
                    o_emit  = 1'b1;
                    status  = STAT_BAD_CK_A;
                    n_phase = PH_SYNC1;
                end
            end
            PH_CHKB: begin
                o_emit  = 1'b1;
                status  = (i_byte == r_sum_b) ? STAT_OK : STAT_BAD_CK_B;
                n_phase = PH_SYNC1;
            end
            default: begin
                // first-sync hunt; unused codes land here too
                n_phase = (i_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    assign carr_soln = r_fine[4:3];

    always_comb begin
        o_result                = '0;
        o_result.frame_status   = status;
        o_result.message_class  = r_class;
        o_result.message_id     = r_id;
        o_result.payload_length = r_len;
        if (status == STAT_OK) begin
            if (r_class == CLASS_NAV && r_id == ID_NAV_PVT) begin
                if (r_len >= PVT_MIN_LEN && (r_cap_a != 32'd0 || r_cap_b != 32'd0)) begin
                    o_result.message_kind = KIND_PVT;
                    o_result.value_a      = r_cap_a;
                    o_result.value_b      = r_cap_b;
                    o_result.accuracy_raw = r_cap_c;
                end
            end else if (r_class == CLASS_NAV && r_id == ID_NAV_HPPOSLLH) begin
                if (r_len >= HPPOS_MIN_LEN) begin
                    o_result.message_kind = KIND_HPPOS;
                    o_result.value_a      = r_cap_a;
                    o_result.value_b      = r_cap_b;
                    o_result.accuracy_raw = r_cap_c;
                    o_result.lon_fine     = r_fine[7:0];
                    o_result.lat_fine     = r_fine[15:8];
                end
            end else if (r_class == CLASS_NAV && r_id == ID_NAV_RELPOSNED) begin
                if (r_len >= RELPOS_MIN_LEN) begin
                    o_result.message_kind = KIND_RELPOS;
                    o_result.value_a      = r_cap_a;
                    o_result.value_b      = r_cap_b;
                    o_result.count_a      = {6'd0, (carr_soln == CARR_RESERVED) ?
                                             CARR_INVALID : carr_soln};
                end
            end else if (r_class == CLASS_NAV && r_id == ID_NAV_SIG) begin
                if (r_len >= SIG_MIN_LEN) begin
                    o_result.message_kind = KIND_SIG;
                    o_result.count_a      = r_healthy;
                    o_result.count_b      = r_corrected;
                end
            end else if (r_class == CLASS_RXM && r_id == ID_RXM_RTCM) begin
                o_result.message_kind = KIND_RTCM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_sum_a     <= 8'h00;
            r_sum_b     <= 8'h00;
            r_class     <= 8'h00;
            r_id        <= 8'h00;
            r_len       <= 16'd0;
            r_idx       <= 16'd0;
            r_cap_a     <= 32'd0;
            r_cap_b     <= 32'd0;
            r_cap_c     <= 32'd0;
            r_fine      <= 16'd0;
            r_sig_limit <= 8'd0;
            r_healthy   <= 8'd0;
            r_corrected <= 8'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_class     <= n_class;
            r_id        <= n_id;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_cap_a     <= n_cap_a;
            r_cap_b     <= n_cap_b;
            r_cap_c     <= n_cap_c;
            r_fine      <= n_fine;
            r_sig_limit <= n_sig_limit;
            r_healthy   <= n_healthy;
            r_corrected <= n_corrected;
        end
    end

endmodule

/* design/ubx_fp_outq.sv */
// Two-entry result queue between the parser and the frame output channel.
// Depends on ubx_fp_pkg.
`timescale 1ns / 1ps

module ubx_fp_outq import ubx_fp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        unique case ({i_push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/ubx_frame_parser_core.sv */
// Top level of the UBX binary frame parser.
// Depends on ubx_fp_pkg, ubx_fp_byte_if, ubx_fp_frame_if, ubx_fp_parser, ubx_fp_outq.
`timescale 1ns / 1ps

// Takes one received byte per transaction on i_rx and accepts a byte every clock
// cycle. Each byte is latched in an input register and then run through one
// step of the frame state machine (sync B5 62, class, id, little-endian
// length, payload, two Fletcher-8 checksum bytes). When a frame ends, on a
// wrong first checksum byte or on the second checksum byte, one result
// transaction with status, header and decoded payload fields is written into
// a register slot of the result queue and then presented on o_frame. A
// two-entry result queue lets bytes keep flowing while a result waits; only
// when that queue is full and the next byte would end another frame does i_rx
// stall.

module ubx_frame_parser_core import ubx_fp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ubx_fp_byte_if.sink    i_rx,
    ubx_fp_frame_if.source o_frame
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       step;
    logic       emit;
    logic       q_full;
    t_result    res;
    t_result    q_data;

    assign step       = r_in_vld && (!q_full || !emit);
    // nothing is taken while reset is held
    assign i_rx.ready = i_rst_n && (!r_in_vld || step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    ubx_fp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (res)
    );

    ubx_fp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step && emit),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_frame.valid),
        .i_ready (o_frame.ready),
        .o_data  (q_data)
    );

    assign o_frame.frame_status   = q_data.frame_status;
    assign o_frame.message_class  = q_data.message_class;
    assign o_frame.message_id     = q_data.message_id;
    assign o_frame.payload_length = q_data.payload_length;
    assign o_frame.message_kind   = q_data.message_kind;
    assign o_frame.value_a        = q_data.value_a;
    assign o_frame.value_b        = q_data.value_b;
    assign o_frame.accuracy_raw   = q_data.accuracy_raw;
    assign o_frame.lat_fine       = q_data.lat_fine;
    assign o_frame.lon_fine       = q_data.lon_fine;
    assign o_frame.count_a        = q_data.count_a;
    assign o_frame.count_b        = q_data.count_b;

endmodule

/* dv/ubx_frame_parser_core_test.sv */
// Self-checking testbench for ubx_frame_parser_core: byte stream in, frame results out.
// Depends on ubx_fp_pkg, ubx_fp_byte_if, ubx_fp_frame_if and the RTL of the core.
`timescale 1ns / 1ps

module ubx_frame_parser_core_test;
    import ubx_fp_pkg::*;

    // well above the slowest legal run: about a thousand bytes, long idle gaps, one long hold
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_BYTES = 120;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [3:0] {
        PH_HUNT_B5, PH_HUNT_62, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI,
        PH_BODY, PH_CK_A, PH_CK_B
    } t_parse_phase;

    typedef enum logic [1:0] {CK_GOOD, CK_WRONG_A, CK_WRONG_B} t_ck_mode;

    logic i_clk;
    logic i_rst_n;

    ubx_fp_byte_if  rx_bus();
    ubx_fp_frame_if frame_bus();

    ubx_frame_parser_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_bus),
        .o_frame (frame_bus)
    );

    // predicted parser state
    t_parse_phase p_phase     = PH_HUNT_B5;
    logic [7:0]   p_sum_a     = '0;
    logic [7:0]   p_sum_b     = '0;
    logic [7:0]   p_class     = '0;
    logic [7:0]   p_id        = '0;
    logic [15:0]  p_len       = '0;
    logic [15:0]  p_idx       = '0;
    logic [31:0]  word_a      = '0;
    logic [31:0]  word_b      = '0;
    logic [31:0]  word_c      = '0;
    logic [15:0]  fine_pair   = '0;
    logic [7:0]   sig_limit   = '0;
    logic [7:0]   healthy_n   = '0;
    logic [7:0]   corrected_n = '0;

    t_result    pending_frames[$];
    int         results_predicted = 0;
    int         fail_count        = 0;
    int         frame_bytes       = 0;
    logic [7:0] body[$];

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_req   = 0;
    int hold_left  = 0;
    int stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("ubx_frame_parser_core: mismatch");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic fletcher_step(inout logic [7:0] a, inout logic [7:0] b, input logic [7:0] d);
        a = a + d;
        b = b + a;
    endtask

    function automatic logic [31:0] place_lane(input logic [31:0] w, input int k, input int base,
                                               input logic [7:0] b);
        logic [31:0] r;
        r = w;
        if (k >= base && k < base + 4) r[8*(k-base) +: 8] = b;
        return r;
    endfunction

    task automatic take_body(input int k, input logic [7:0] b);
        int blk;
        if (p_class != CLASS_NAV) return;
        case (p_id)
            ID_NAV_PVT: begin
                word_b = place_lane(word_b, k, 24, b);
                word_a = place_lane(word_a, k, 28, b);
                word_c = place_lane(word_c, k, 40, b);
            end
            ID_NAV_HPPOSLLH: begin
                word_b = place_lane(word_b, k, 8, b);
                word_a = place_lane(word_a, k, 12, b);
                word_c = place_lane(word_c, k, 28, b);
                if (k == 24) fine_pair[7:0] = b;
                if (k == 25) fine_pair[15:8] = b;
            end
            ID_NAV_RELPOSNED: begin
                word_a = place_lane(word_a, k, 8, b);
                word_b = place_lane(word_b, k, 12, b);
                if (k == 60) fine_pair = {8'h00, b};
            end
            ID_NAV_SIG: begin
                if (k == 5) sig_limit = b;
                // flags byte of signal block blk sits at offset 18 + 16*blk
                if (k >= 18 && ((k - 18) % 16) == 0) begin
                    blk = (k - 18) / 16;
                    if (!sig_limit[7] && blk < sig_limit && k + 1 < p_len
                        && b[1:0] == 2'b01 && b[3]) begin
                        healthy_n = healthy_n + 8'd1;
                        if (b[7]) corrected_n = corrected_n + 8'd1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic finish_frame(input logic [1:0] status);
        t_result r;
        logic [1:0] cs;
        r = '0;
        r.frame_status   = status;
        r.message_class  = p_class;
        r.message_id     = p_id;
        r.payload_length = p_len;
        if (status == STAT_OK) begin
            if (p_class == CLASS_NAV && p_id == ID_NAV_PVT) begin
                if (p_len >= PVT_MIN_LEN && (word_a != 0 || word_b != 0)) begin
                    r.message_kind = KIND_PVT;
                    r.value_a      = word_a;
                    r.value_b      = word_b;
                    r.accuracy_raw = word_c;
                end
            end else if (p_class == CLASS_NAV && p_id == ID_NAV_HPPOSLLH) begin
                if (p_len >= HPPOS_MIN_LEN) begin
                    r.message_kind = KIND_HPPOS;
                    r.value_a      = word_a;
                    r.value_b      = word_b;
                    r.accuracy_raw = word_c;
                    r.lat_fine     = fine_pair[15:8];
                    r.lon_fine     = fine_pair[7:0];
                end
            end else if (p_class == CLASS_NAV && p_id == ID_NAV_RELPOSNED) begin
                if (p_len >= RELPOS_MIN_LEN) begin
                    cs = fine_pair[4:3];
                    r.message_kind = KIND_RELPOS;
                    r.value_a      = word_a;
                    r.value_b      = word_b;
                    r.count_a      = {6'b0, (cs == CARR_RESERVED) ? CARR_INVALID : cs};
                end
            end else if (p_class == CLASS_NAV && p_id == ID_NAV_SIG) begin
                if (p_len >= SIG_MIN_LEN) begin
                    r.message_kind = KIND_SIG;
                    r.count_a      = healthy_n;
                    r.count_b      = corrected_n;
                end
            end else if (p_class == CLASS_RXM && p_id == ID_RXM_RTCM) begin
                r.message_kind = KIND_RTCM;
            end
        end
        pending_frames.insert(pending_frames.size(), r);
        results_predicted++;
    endtask

    task automatic track_byte(input logic [7:0] b);
        case (p_phase)
            PH_HUNT_62: begin
                if (b == SYNC_SECOND) begin
                    p_phase = PH_CLASS;
                    p_sum_a = '0;
                    p_sum_b = '0;
                end else begin
                    p_phase = PH_HUNT_B5;
                end
            end
            PH_CLASS: begin
                p_class = b;
                fletcher_step(p_sum_a, p_sum_b, b);
                p_phase = PH_ID;
            end
            PH_ID: begin
                p_id = b;
                fletcher_step(p_sum_a, p_sum_b, b);
                p_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                p_len = {8'h00, b};
                fletcher_step(p_sum_a, p_sum_b, b);
                p_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                p_len[15:8] = b;
                fletcher_step(p_sum_a, p_sum_b, b);
                p_idx       = '0;
                word_a      = '0;
                word_b      = '0;
                word_c      = '0;
                fine_pair   = '0;
                sig_limit   = '0;
                healthy_n   = '0;
                corrected_n = '0;
                p_phase = (p_len == 16'd0) ? PH_CK_A : PH_BODY;
            end
            PH_BODY: begin
                fletcher_step(p_sum_a, p_sum_b, b);
                take_body(int'(p_idx), b);
                p_idx = p_idx + 16'd1;
                if (p_idx >= p_len) p_phase = PH_CK_A;
            end
            PH_CK_A: begin
                if (b == p_sum_a) begin
                    p_phase = PH_CK_B;
                end else begin
                    finish_frame(STAT_BAD_CK_A);
                    p_phase = PH_HUNT_B5;
                end
            end
            PH_CK_B: begin
                finish_frame((b == p_sum_b) ? STAT_OK : STAT_BAD_CK_B);
                p_phase = PH_HUNT_B5;
            end
            default: p_phase = (b == SYNC_FIRST) ? PH_HUNT_62 : PH_HUNT_B5;
        endcase
    endtask

    // called and returns at a falling edge; valid is left high after the transaction
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            rx_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_bus.valid   = 1'b1;
        rx_bus.rx_byte = b;
        @(posedge i_clk);
        while (!rx_bus.ready) @(posedge i_clk);
        track_byte(b);
        @(negedge i_clk);
    endtask

    task automatic fill_body(input int n);
        body.delete();
        repeat (n) body.insert(body.size(), 8'($urandom_range(0, 255)));
    endtask

    task automatic set_byte(input int off, input logic [7:0] v);
        if (off < body.size()) body[off] = v;
    endtask

    task automatic set_word(input int off, input logic [31:0] v);
        for (int i = 0; i < 4; i++) set_byte(off + i, v[8*i +: 8]);
    endtask

    task automatic push_frame(input logic [7:0] cls, input logic [7:0] id, input t_ck_mode mode);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] n;
        a = '0;
        b = '0;
        n = 16'(body.size());
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        fletcher_step(a, b, cls);
        push_byte(cls);
        fletcher_step(a, b, id);
        push_byte(id);
        fletcher_step(a, b, n[7:0]);
        push_byte(n[7:0]);
        fletcher_step(a, b, n[15:8]);
        push_byte(n[15:8]);
        for (int i = 0; i < body.size(); i++) begin
            fletcher_step(a, b, body[i]);
            push_byte(body[i]);
        end
        case (mode)
            CK_WRONG_A: push_byte(a ^ 8'($urandom_range(1, 255)));
            CK_WRONG_B: begin
                push_byte(a);
                push_byte(b ^ 8'($urandom_range(1, 255)));
            end
            default: begin
                push_byte(a);
                push_byte(b);
            end
        endcase
        frame_bytes += body.size() + 8;
    endtask

    // output side: ready changes at the falling edge
    initial begin
        frame_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                frame_bus.ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                frame_bus.ready = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                frame_bus.ready = 1'b0;
                stall_left = pick_gap();
            end else begin
                frame_bus.ready = 1'b1;
            end
        end
    end

    function automatic bit field_bad(input string name, input logic [31:0] want,
                                     input logic [31:0] seen);
        if (want !== seen) begin
            if (fail_count < 10)
                $display("  %s: expected %h, got %h", name, want, seen);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_frame(input t_result seen);
        t_result want;
        bit bad;
        if (pending_frames.size() == 0) begin
            if (fail_count < 10)
                $display("unexpected frame result at %0t: class %h id %h",
                         $realtime, seen.message_class, seen.message_id);
            fail_count++;
            return;
        end
        want = pending_frames.pop_front();
        if (want !== seen && fail_count < 10)
            $display("frame result mismatch at %0t:", $realtime);
        bad = 1'b0;
        bad |= field_bad("frame_status",   32'(want.frame_status),   32'(seen.frame_status));
        bad |= field_bad("message_class",  32'(want.message_class),  32'(seen.message_class));
        bad |= field_bad("message_id",     32'(want.message_id),     32'(seen.message_id));
        bad |= field_bad("payload_length", 32'(want.payload_length), 32'(seen.payload_length));
        bad |= field_bad("message_kind",   32'(want.message_kind),   32'(seen.message_kind));
        bad |= field_bad("value_a",        want.value_a,             seen.value_a);
        bad |= field_bad("value_b",        want.value_b,             seen.value_b);
        bad |= field_bad("accuracy_raw",   want.accuracy_raw,        seen.accuracy_raw);
        bad |= field_bad("lat_fine",       32'(want.lat_fine),       32'(seen.lat_fine));
        bad |= field_bad("lon_fine",       32'(want.lon_fine),       32'(seen.lon_fine));
        bad |= field_bad("count_a",        32'(want.count_a),        32'(seen.count_a));
        bad |= field_bad("count_b",        32'(want.count_b),        32'(seen.count_b));
        if (bad) fail_count++;
    endtask

    initial begin
        t_result seen;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && frame_bus.valid && frame_bus.ready) begin
                seen.frame_status   = frame_bus.frame_status;
                seen.message_class  = frame_bus.message_class;
                seen.message_id     = frame_bus.message_id;
                seen.payload_length = frame_bus.payload_length;
                seen.message_kind   = frame_bus.message_kind;
                seen.value_a        = frame_bus.value_a;
                seen.value_b        = frame_bus.value_b;
                seen.accuracy_raw   = frame_bus.accuracy_raw;
                seen.lat_fine       = frame_bus.lat_fine;
                seen.lon_fine       = frame_bus.lon_fine;
                seen.count_a        = frame_bus.count_a;
                seen.count_b        = frame_bus.count_b;
                check_frame(seen);
            end
        end
    end

    task automatic test_sync_hunt();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_FIRST);
        push_byte(8'h00);
        push_byte(SYNC_SECOND);
        // a repeated B5 is not retried as the start of a new sync pair
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        body.delete();
        push_frame(8'h00, 8'h00, CK_GOOD);
        push_frame(8'hFF, 8'hFF, CK_GOOD);
    endtask

    task automatic test_checksum_errors();
        body.delete();
        push_frame(8'h0A, 8'h05, CK_WRONG_A);
        fill_body(3);
        push_frame(CLASS_NAV, ID_NAV_PVT, CK_WRONG_B);
        fill_body(44);
        push_frame(CLASS_NAV, ID_NAV_PVT, CK_WRONG_A);
    endtask

    task automatic test_nav_pvt();
        fill_body(48);
        set_word(24, 32'h8000_0000);
        set_word(28, 32'h7FFF_FFFF);
        set_word(40, 32'hFFFF_FFFF);
        push_frame(CLASS_NAV, ID_NAV_PVT, CK_GOOD);
        fill_body(44);
        set_word(24, 32'h0);
        set_word(28, 32'h0);
        push_frame(CLASS_NAV, ID_NAV_PVT, CK_GOOD);
        fill_body(44);
        set_word(24, 32'h0);
        set_word(28, 32'h0000_0001);
        set_word(40, 32'h0);
        push_frame(CLASS_NAV, ID_NAV_PVT, CK_GOOD);
        fill_body(43);
        push_frame(CLASS_NAV, ID_NAV_PVT, CK_GOOD);
    endtask

    task automatic test_hp_position();
        fill_body(36);
        set_word(8, 32'h7FFF_FFFF);
        set_word(12, 32'h8000_0000);
        set_byte(24, 8'h80);
        set_byte(25, 8'h7F);
        set_word(28, 32'hFFFF_FFFF);
        push_frame(CLASS_NAV, ID_NAV_HPPOSLLH, CK_GOOD);
        fill_body(31);
        push_frame(CLASS_NAV, ID_NAV_HPPOSLLH, CK_GOOD);
    endtask

    task automatic test_relative_position();
        fill_body(64);
        set_byte(60, 8'h18);    // carrier solution field reads 3
        push_frame(CLASS_NAV, ID_NAV_RELPOSNED, CK_GOOD);
        fill_body(64);
        set_byte(60, 8'h10);
        push_frame(CLASS_NAV, ID_NAV_RELPOSNED, CK_GOOD);
        fill_body(63);
        push_frame(CLASS_NAV, ID_NAV_RELPOSNED, CK_GOOD);
    endtask

    task automatic test_signal_info();
        // three blocks announced, the last flags byte is the final payload byte
        fill_body(51);
        set_byte(5, 8'd3);
        set_byte(18, 8'h89);
        set_byte(34, 8'h89);
        set_byte(50, 8'h89);
        push_frame(CLASS_NAV, ID_NAV_SIG, CK_GOOD);
        fill_body(70);
        set_byte(5, 8'd4);
        set_byte(18, 8'h89);
        set_byte(34, 8'h09);
        set_byte(50, 8'h0A);
        set_byte(66, 8'h81);
        push_frame(CLASS_NAV, ID_NAV_SIG, CK_GOOD);
        fill_body(24);
        set_byte(5, 8'h80);
        set_byte(18, 8'h89);
        push_frame(CLASS_NAV, ID_NAV_SIG, CK_GOOD);
        fill_body(7);
        push_frame(CLASS_NAV, ID_NAV_SIG, CK_GOOD);
    endtask

    task automatic test_correction_stream();
        fill_body(10);
        push_frame(CLASS_RXM, ID_RXM_RTCM, CK_GOOD);
        push_frame(CLASS_RXM, ID_RXM_RTCM, CK_WRONG_B);
    endtask

    // length with a nonzero high byte
    task automatic test_long_payload();
        tx_idle_en = 1'b0;
        fill_body(256);
        push_frame(CLASS_NAV, ID_NAV_PVT, CK_GOOD);
        tx_idle_en = 1'b1;
    endtask

    task automatic test_output_stall();
        rx_bus.valid = 1'b0;
        @(posedge i_clk);
        hold_req = 400;
        @(negedge i_clk);
        tx_idle_en = 1'b0;
        body.delete();
        repeat (8) push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), CK_GOOD);
        tx_idle_en = 1'b1;
    endtask

    task automatic random_frame();
        int n;
        int lim;
        int r;
        bit short_len;
        logic [7:0] cls;
        logic [7:0] id;
        logic [7:0] f;
        t_ck_mode mode;
        r = $urandom_range(0, 99);
        mode = (r < 10) ? CK_WRONG_A : (r < 20) ? CK_WRONG_B : CK_GOOD;
        short_len = ($urandom_range(0, 9) == 0);
        cls = CLASS_NAV;
        case ($urandom_range(0, 6))
            0: begin
                id = ID_NAV_PVT;
                fill_body(short_len ? $urandom_range(0, 43) : $urandom_range(44, 100));
                if ($urandom_range(0, 9) == 0) begin
                    set_word(24, 32'h0);
                    set_word(28, 32'h0);
                end
            end
            1: begin
                id = ID_NAV_HPPOSLLH;
                fill_body(short_len ? $urandom_range(0, 31) : $urandom_range(32, 40));
            end
            2: begin
                id = ID_NAV_RELPOSNED;
                fill_body(short_len ? $urandom_range(0, 63) : $urandom_range(64, 72));
            end
            3: begin
                id = ID_NAV_SIG;
                lim = ($urandom_range(0, 9) == 0) ? 128 + $urandom_range(0, 127)
                                                  : $urandom_range(0, 6);
                n = short_len ? $urandom_range(0, 7)
                              : 8 + 16 * $urandom_range(0, 7) + $urandom_range(0, 15);
                fill_body(n);
                set_byte(5, 8'(lim));
                for (int i = 18; i < n; i += 16) begin
                    if ($urandom_range(0, 2) != 0) begin
                        f = 8'($urandom_range(0, 255));
                        f[1:0] = 2'b01;
                        f[3] = 1'b1;
                        set_byte(i, f);
                    end
                end
            end
            4: begin
                cls = CLASS_RXM;
                id  = ID_RXM_RTCM;
                fill_body($urandom_range(0, 30));
            end
            5: begin
                id = 8'($urandom_range(0, 255));
                fill_body($urandom_range(0, 24));
            end
            default: begin
                cls = 8'($urandom_range(0, 255));
                id  = 8'($urandom_range(0, 255));
                fill_body($urandom_range(0, 24));
            end
        endcase
        push_frame(cls, id, mode);
    endtask

    task automatic test_random_stream();
        int r;
        logic [7:0] f;
        frame_bytes = 0;
        while (frame_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 19) == 0) tx_idle_en = !tx_idle_en;
            if ($urandom_range(0, 19) == 0) rx_idle_en = !rx_idle_en;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // line noise that never starts a sync pair
                repeat ($urandom_range(1, 4)) begin
                    f = 8'($urandom_range(0, 255));
                    if (f == SYNC_FIRST) f = 8'h00;
                    push_byte(f);
                end
            end else if (r < 14) begin
                // broken sync pair, never completed into a header
                push_byte(SYNC_FIRST);
                f = $urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom_range(0, 255));
                if (f == SYNC_SECOND) f = 8'h00;
                push_byte(f);
            end else begin
                random_frame();
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_sync_hunt();
        test_checksum_errors();
        test_nav_pvt();
        test_hp_position();
        test_relative_position();
        test_signal_info();
        test_correction_stream();
        test_long_payload();
        test_output_stall();
        test_random_stream();

        rx_bus.valid = 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_frames.size() == 0)
            $display("ubx_frame_parser_core: match");
        else
            $display("ubx_frame_parser_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/ubx_fp_pkg.sv
design/ubx_fp_byte_if.sv
design/ubx_fp_frame_if.sv
design/ubx_fp_parser.sv
design/ubx_fp_outq.sv
design/ubx_frame_parser_core.sv
dv/ubx_frame_parser_core_test.sv
